// ===== sv/bvm_pkg.sv =====
// Shared types and codes for the byte VM ALU executor.
`default_nettype none

package bvm_pkg;

   // Item actions
   localparam logic [1:0] ACT_EXEC = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   // Instruction opcodes
   localparam logic [7:0] OP_ADD = 8'd0;
   localparam logic [7:0] OP_SUB = 8'd1;
   localparam logic [7:0] OP_MUL = 8'd2;
   localparam logic [7:0] OP_DIV = 8'd3;

   // Result status codes
   localparam logic [2:0] STAT_EXECUTED = 3'd0;
   localparam logic [2:0] STAT_LOADED   = 3'd1;
   localparam logic [2:0] STAT_END_HALT = 3'd2;
   localparam logic [2:0] STAT_DIV_HALT = 3'd3;
   localparam logic [2:0] STAT_UNK_HALT = 3'd4;
   localparam logic [2:0] STAT_REFUSED  = 3'd5;
   localparam logic [2:0] STAT_IGNORED  = 3'd6;

   localparam int CONST_COUNT_W = 9;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] opcode;
      logic [7:0] dest_slot;
      logic [7:0] src_a_slot;
      logic [7:0] src_b_slot;
      logic [7:0] load_value;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] result_slot;
      logic [7:0] result_value;
      logic       halted;
   } rsp_item_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic launch;   // capture item, read both operand slots
      logic retire;   // compute, write back, emit result beat
   } ctl_cmd_type;

endpackage

`default_nettype wire

// ===== sv/bvm_controller.sv =====
// Sequencing state machine for the byte VM ALU executor.
`default_nettype none

module bvm_controller
   import bvm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output ctl_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: IDLE reads the operands on start, EXEC executes and returns to IDLE
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      busy       = 1'b0;
      cmd.launch = 1'b0;
      cmd.retire = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.launch = start;
         end
         ST_EXEC: begin
            busy       = 1'b1;
            cmd.retire = 1'b1;
         end
      endcase
   end

   // Every accepted item retires in the following cycle
   a_launch_retires: assert property (@(posedge clock) disable iff (reset)
      cmd.launch |=> cmd.retire)
      else $error("accepted item did not retire");

   // Retire lasts a single cycle per item
   a_retire_single: assert property (@(posedge clock) disable iff (reset)
      cmd.retire |=> !cmd.retire)
      else $error("retire held for two cycles");

   // No new item while one is retiring
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.retire |-> !cmd.launch)
      else $error("launch overlaps retire");

endmodule

`default_nettype wire

// ===== sv/bvm_datapath.sv =====
// Value store, operand fetch, ALU and status decode for the byte VM.
`default_nettype none

module bvm_datapath
   import bvm_pkg::*;
#(
   parameter int SLOT_COUNT = 256
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_cmd_type              cmd,
   input  wire req_item_type             req_item,
   input  wire logic                     csr_we,
   input  wire logic [CONST_COUNT_W-1:0] csr_wdata,
   output rsp_item_type                  rsp_item
);

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

   logic [7:0]              store_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]   valid_ff;
   req_item_type            item_ff;
   logic [7:0]              rd_a_ff;
   logic [7:0]              rd_b_ff;
   logic                    rd_a_ok_ff;
   logic                    rd_b_ok_ff;
   logic                    halt_ff;
   logic                    halt_in;
   logic [CONST_COUNT_W-1:0] const_count_ff;

   logic                    a_in_range;
   logic                    b_in_range;
   logic                    dest_in_range;
   logic [ADDR_W-1:0]       a_idx;
   logic [ADDR_W-1:0]       b_idx;
   logic [ADDR_W-1:0]       w_idx;
   logic [7:0]              opnd_a;
   logic [7:0]              opnd_b;
   logic [15:0]             product;
   logic [7:0]              alu_out;
   logic                    wr_req;
   logic [7:0]              wr_data;
   logic                    wr_en;

   assign a_in_range    = {1'b0, req_item.src_a_slot} < SLOT_LIMIT;
   assign b_in_range    = {1'b0, req_item.src_b_slot} < SLOT_LIMIT;
   assign dest_in_range = {1'b0, item_ff.dest_slot} < SLOT_LIMIT;
   assign a_idx         = req_item.src_a_slot[ADDR_W-1:0];
   assign b_idx         = req_item.src_b_slot[ADDR_W-1:0];
   assign w_idx         = item_ff.dest_slot[ADDR_W-1:0];

   // Hold the constant count register
   always_ff @(posedge clock) begin
      if (reset) begin
         const_count_ff <= '0;
      end else if (csr_we) begin
         const_count_ff <= csr_wdata;
      end
   end

   // Capture the item and read both operands on launch; write back on retire
   always_ff @(posedge clock) begin
      if (cmd.launch) begin
         item_ff    <= req_item;
         rd_a_ff    <= store_mem[a_idx];
         rd_b_ff    <= store_mem[b_idx];
         rd_a_ok_ff <= a_in_range && valid_ff[a_idx];
         rd_b_ok_ff <= b_in_range && valid_ff[b_idx];
      end
      if (wr_en) begin
         store_mem[w_idx] <= wr_data;
      end
   end

   // Mark written slots; unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[w_idx] <= 1'b1;
      end
   end

   // Hold the halt flag
   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff <= 1'b0;
      end else begin
         halt_ff <= halt_in;
      end
   end

   // ALU
   assign opnd_a  = rd_a_ok_ff ? rd_a_ff : 8'd0;
   assign opnd_b  = rd_b_ok_ff ? rd_b_ff : 8'd0;
   assign product = opnd_a * opnd_b;

   always_comb begin
      case (item_ff.opcode)
         OP_ADD:  alu_out = opnd_a + opnd_b;
         OP_SUB:  alu_out = opnd_a - opnd_b;
         default: alu_out = product[7:0];
      endcase
   end

   // Decode the item into status, write back and halt
   always_comb begin
      rsp_item.status       = STAT_IGNORED;
      rsp_item.result_slot  = 8'd0;
      rsp_item.result_value = 8'd0;
      wr_req                = 1'b0;
      wr_data               = item_ff.load_value;
      halt_in               = halt_ff;
      if (!halt_ff) begin
         unique case (item_ff.action)
            ACT_LOAD: begin
               rsp_item.status       = STAT_LOADED;
               rsp_item.result_slot  = item_ff.dest_slot;
               rsp_item.result_value = item_ff.load_value;
               wr_req                = 1'b1;
            end
            ACT_EXEC: begin
               unique case (item_ff.opcode) inside
                  OP_ADD, OP_SUB, OP_MUL: begin
                     rsp_item.result_slot = item_ff.dest_slot;
                     if ({1'b0, item_ff.dest_slot} < const_count_ff) begin
                        rsp_item.status = STAT_REFUSED;
                     end else begin
                        rsp_item.status       = STAT_EXECUTED;
                        rsp_item.result_value = alu_out;
                        wr_req                = 1'b1;
                        wr_data               = alu_out;
                     end
                  end
                  OP_DIV: begin
                     rsp_item.status = STAT_DIV_HALT;
                     halt_in         = 1'b1;
                  end
                  default: begin
                     rsp_item.status = STAT_UNK_HALT;
                     halt_in         = 1'b1;
                  end
               endcase
            end
            default: begin
               // end of program, and the spare action code
               rsp_item.status = STAT_END_HALT;
               halt_in         = 1'b1;
            end
         endcase
      end
      if (!cmd.retire) begin
         halt_in = halt_ff;
      end
      rsp_item.halted = halt_in;
   end

   // Drop writes beyond the store
   assign wr_en = cmd.retire && wr_req && dest_in_range;

endmodule

`default_nettype wire

// ===== sv/byte_vm_alu_executor_core.sv =====
// Top level of the byte VM ALU executor: controller plus datapath.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_item          in         start && !busy
//   response  rsp_strobe, rsp_item           out        one-cycle strobe
//   csr       csr_we, csr_wdata              in         write on csr_we
//
// Each item runs as follows: the accept edge reads both operand slots into
// registers, the next cycle computes, writes back and drives the result
// beat. The store's synchronous read followed by write-back sets this split.
// Reset clears the halt flag, const_count and the per-slot valid bits at
// once, so the store reads as all zero with no clearing pass.
// The receiver cannot stall; busy is high only during the execute cycle.
`default_nettype none

module byte_vm_alu_executor_core
   import bvm_pkg::*;
#(
   parameter int SLOT_COUNT = 256
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_item_type             req_item,
   output logic                          rsp_strobe,
   output rsp_item_type                  rsp_item,
   input  wire logic                     csr_we,
   input  wire logic [CONST_COUNT_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;

   bvm_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   bvm_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

   // Result beat follows the retire command
   assign rsp_strobe = cmd.retire;

endmodule

`default_nettype wire
